// File: hw/rtl/dwab_pkg.sv
// Shared constants and types for the dual window average balance block.
package dwab_pkg;

    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_BITS-1:0] LONG_WINDOW_RESET  = 7'd42;
    localparam logic [CFG_BITS-1:0] SHORT_WINDOW_RESET = 7'd7;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LONG_WINDOW  = 1'b0,
        REG_SHORT_WINDOW = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_SUM,
        BACK_MUL,
        BACK_PREP,
        BACK_DIV,
        BACK_OUT
    } back_state_t;

endpackage

// File: hw/rtl/dwab_if.sv
// Request channels for samples in and balance results out.
interface dwab_in_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_of_series;

    modport source (output valid, sample, last_of_series, input ready);
    modport sink (input valid, sample, last_of_series, output ready);
endinterface

interface dwab_out_if #(parameter int SAMPLE_BITS = 12);
    logic                      valid;
    logic                      ready;
    logic signed [SAMPLE_BITS:0] balance;

    modport source (output valid, balance, input ready);
    modport sink (input valid, balance, output ready);
endinterface

// File: hw/rtl/dwab_cmd_fifo.sv
// Small command queue between the front and the back.
module dwab_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [IDX_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_BITS'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + IDX_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_BITS'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + IDX_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/dwab_hist_ram.sv
// Sample history memory: one write port, one registered read port.
module dwab_hist_ram #(
    parameter int DEPTH = 70,
    parameter int WIDTH = 12,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

endmodule

// File: hw/rtl/dwab_front.sv
// Front part: window registers, sample intake, history write and command issue.
module dwab_front #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 12,
    parameter int HIST_DEPTH  = 70,
    localparam int LEN_BITS = $clog2(MAX_WINDOW + 1),
    localparam int PTR_BITS = $clog2(HIST_DEPTH),
    localparam int CMD_BITS = PTR_BITS + 2 * LEN_BITS + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    dwab_in_if.sink                             in_ch,
    input  logic                                cfg_wen,
    input  logic [dwab_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dwab_pkg::CFG_BITS-1:0]       cfg_data,
    output logic                                hist_we,
    output logic [PTR_BITS-1:0]                 hist_waddr,
    output logic [SAMPLE_BITS-1:0]              hist_wdata,
    output logic                                cmd_push,
    output logic [CMD_BITS-1:0]                 cmd_data,
    input  logic                                cmd_full
);
    import dwab_pkg::*;

    localparam int CW = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;

    typedef struct packed {
        logic [PTR_BITS-1:0] ptr;
        logic [LEN_BITS-1:0] long_len;
        logic [LEN_BITS-1:0] short_len;
        logic                emit;
    } cmd_t;

    function automatic logic [LEN_BITS-1:0] clamp_len(input logic [CFG_BITS-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w == '0)
        begin
            clamp_len = LEN_BITS'(1);
        end
        else if (w > CW'(MAX_WINDOW))
        begin
            clamp_len = LEN_BITS'(MAX_WINDOW);
        end
        else
        begin
            clamp_len = LEN_BITS'(w);
        end
    endfunction

    logic [CFG_BITS-1:0] long_window_reg, short_window_reg;
    logic [LEN_BITS-1:0] fill_reg, fill_next;
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LEN_BITS-1:0] long_len, short_clamped, short_len, fill_inc;
    logic                accept;
    cmd_t                cmd;

    assign in_ch.ready   = !cmd_full;
    assign accept        = in_ch.valid && !cmd_full;

    assign long_len      = clamp_len(long_window_reg);
    assign short_clamped = clamp_len(short_window_reg);
    assign short_len     = (short_clamped > long_len) ? long_len : short_clamped;

    // The count saturates once a full maximum window has been seen.
    assign fill_inc = (fill_reg < LEN_BITS'(MAX_WINDOW)) ? fill_reg + LEN_BITS'(1) : fill_reg;

    assign cmd.ptr       = wr_ptr_reg;
    assign cmd.long_len  = long_len;
    assign cmd.short_len = short_len;
    assign cmd.emit      = (fill_inc >= long_len);

    assign hist_we    = accept;
    assign hist_waddr = wr_ptr_reg;
    assign hist_wdata = in_ch.sample;
    assign cmd_push   = accept;
    assign cmd_data   = cmd;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(HIST_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + PTR_BITS'(1);
            fill_next   = in_ch.last_of_series ? '0 : fill_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_window_reg  <= LONG_WINDOW_RESET;
            short_window_reg <= SHORT_WINDOW_RESET;
            fill_reg         <= '0;
            wr_ptr_reg       <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_LONG_WINDOW:  long_window_reg  <= cfg_data;
                    REG_SHORT_WINDOW: short_window_reg <= cfg_data;
                endcase
            end
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

endmodule

// File: hw/rtl/dwab_back.sv
// Back part: window sums from history, serial cross products, rounding divider.
module dwab_back #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 12,
    parameter int HIST_DEPTH  = 70,
    localparam int LEN_BITS = $clog2(MAX_WINDOW + 1),
    localparam int PTR_BITS = $clog2(HIST_DEPTH),
    localparam int CMD_BITS = PTR_BITS + 2 * LEN_BITS + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CMD_BITS-1:0]    cmd_data,
    input  logic                   cmd_empty,
    output logic                   cmd_pop,
    output logic [PTR_BITS-1:0]    hist_raddr,
    input  logic [SAMPLE_BITS-1:0] hist_rdata,
    dwab_out_if.source             out_ch
);
    import dwab_pkg::*;

    localparam int SUM_BITS  = SAMPLE_BITS + LEN_BITS;
    localparam int NUM_BITS  = SUM_BITS + LEN_BITS + 1;
    localparam int DEN_BITS  = 2 * LEN_BITS;
    localparam int QB        = SAMPLE_BITS + 1;
    localparam int DW        = SAMPLE_BITS + 2 * LEN_BITS + 3;
    localparam int MAX_STEPS = (LEN_BITS > QB) ? LEN_BITS : QB;
    localparam int STEP_BITS = $clog2(MAX_STEPS + 1);

    typedef struct packed {
        logic [PTR_BITS-1:0] ptr;
        logic [LEN_BITS-1:0] long_len;
        logic [LEN_BITS-1:0] short_len;
        logic                emit;
    } cmd_t;

    back_state_t state_reg, state_next;

    logic [PTR_BITS-1:0]  addr_reg, addr_next;
    logic [LEN_BITS-1:0]  len_l_reg, len_l_next, len_s_reg, len_s_next;
    logic [LEN_BITS-1:0]  issue_cnt_reg, issue_cnt_next, acc_cnt_reg, acc_cnt_next;
    logic                 rvalid_reg, rvalid_next;
    logic [SUM_BITS-1:0]  acc_reg, acc_next, lsum_reg, lsum_next, ssum_reg, ssum_next;
    logic [LEN_BITS-1:0]  mul_l_reg, mul_l_next, mul_s_reg, mul_s_next;
    logic signed [NUM_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS-1:0]  den_reg, den_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 neg_reg, neg_next;
    logic [DW-1:0]        rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QB-1:0]        q_reg, q_next;
    logic                 out_valid_reg, out_valid_next;
    logic [QB-1:0]        balance_reg, balance_next;

    cmd_t                 cmd;
    logic                 issuing, acc_last, out_free;
    logic [LEN_BITS-1:0]  acc_cnt_inc;
    logic [SUM_BITS-1:0]  acc_sum;
    logic [NUM_BITS-1:0]  add_l, add_s, mag;

    assign cmd         = cmd_t'(cmd_data);
    assign cmd_pop     = (state_reg == BACK_IDLE) && !cmd_empty;
    assign hist_raddr  = addr_reg;
    assign issuing     = (state_reg == BACK_SUM) && (issue_cnt_reg != len_l_reg);
    assign acc_cnt_inc = acc_cnt_reg + LEN_BITS'(1);
    assign acc_sum     = acc_reg + SUM_BITS'(hist_rdata);
    assign acc_last    = rvalid_reg && (acc_cnt_inc == len_l_reg);
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign add_l = mul_s_reg[LEN_BITS-1] ? NUM_BITS'(lsum_reg) : '0;
    assign add_s = mul_l_reg[LEN_BITS-1] ? NUM_BITS'(ssum_reg) : '0;
    assign mag   = num_reg[NUM_BITS-1] ? NUM_BITS'(-num_reg) : NUM_BITS'(num_reg);

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.balance = balance_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!cmd_empty && cmd.emit)
                begin
                    state_next = BACK_SUM;
                end
            end
            BACK_SUM:
            begin
                if (acc_last)
                begin
                    state_next = BACK_MUL;
                end
            end
            BACK_MUL:
            begin
                if (step_reg == STEP_BITS'(LEN_BITS - 1))
                begin
                    state_next = BACK_PREP;
                end
            end
            BACK_PREP:
            begin
                state_next = BACK_DIV;
            end
            BACK_DIV:
            begin
                if (step_reg == STEP_BITS'(QB - 1))
                begin
                    state_next = BACK_OUT;
                end
            end
            BACK_OUT:
            begin
                if (out_free)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        addr_next      = addr_reg;
        len_l_next     = len_l_reg;
        len_s_next     = len_s_reg;
        issue_cnt_next = issue_cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        rvalid_next    = issuing;
        acc_next       = acc_reg;
        lsum_next      = lsum_reg;
        ssum_next      = ssum_reg;
        mul_l_next     = mul_l_reg;
        mul_s_next     = mul_s_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        balance_next   = balance_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BACK_IDLE:
            begin
                addr_next      = cmd.ptr;
                len_l_next     = cmd.long_len;
                len_s_next     = cmd.short_len;
                issue_cnt_next = '0;
                acc_cnt_next   = '0;
                acc_next       = '0;
            end
            BACK_SUM:
            begin
                // Reads walk backward from the newest sample, one per cycle.
                if (issuing)
                begin
                    addr_next      = (addr_reg == '0) ? PTR_BITS'(HIST_DEPTH - 1)
                                                      : addr_reg - PTR_BITS'(1);
                    issue_cnt_next = issue_cnt_reg + LEN_BITS'(1);
                end
                if (rvalid_reg)
                begin
                    acc_next     = acc_sum;
                    acc_cnt_next = acc_cnt_inc;
                    if (acc_cnt_inc == len_s_reg)
                    begin
                        ssum_next = acc_sum;
                    end
                    if (acc_cnt_inc == len_l_reg)
                    begin
                        lsum_next = acc_sum;
                    end
                end
                mul_l_next = len_l_reg;
                mul_s_next = len_s_reg;
                num_next   = '0;
                den_next   = '0;
                step_next  = '0;
            end
            BACK_MUL:
            begin
                // Most significant bit first: num = lsum*S - ssum*L, den = L*S.
                num_next   = (num_reg <<< 1) + $signed(add_l) - $signed(add_s);
                den_next   = (den_reg << 1)
                           + (mul_s_reg[LEN_BITS-1] ? DEN_BITS'(len_l_reg) : '0);
                mul_l_next = mul_l_reg << 1;
                mul_s_next = mul_s_reg << 1;
                step_next  = step_reg + STEP_BITS'(1);
            end
            BACK_PREP:
            begin
                // Rounding half away from zero: (2|num| + den) / (2 den).
                neg_next  = num_reg[NUM_BITS-1];
                rem_next  = (DW'(mag) << 1) + DW'(den_reg);
                dsh_next  = DW'(den_reg) << QB;
                q_next    = '0;
                step_next = '0;
            end
            BACK_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[QB-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + STEP_BITS'(1);
            end
            BACK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    balance_next   = neg_reg ? QB'(0) - q_reg : q_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        len_l_reg     <= len_l_next;
        len_s_reg     <= len_s_next;
        issue_cnt_reg <= issue_cnt_next;
        acc_cnt_reg   <= acc_cnt_next;
        acc_reg       <= acc_next;
        lsum_reg      <= lsum_next;
        ssum_reg      <= ssum_next;
        mul_l_reg     <= mul_l_next;
        mul_s_reg     <= mul_s_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        step_reg      <= step_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        balance_reg   <= balance_next;
    end

endmodule

// File: hw/rtl/dual_window_average_balance.sv
// A sample that yields a balance occupies the back part for its window sums (one history
// read per window sample), the serial products (one step per length bit) and the division
// (one step per quotient bit); other samples are popped from the queue while the back is idle.
// The front takes requests while the four-entry command queue has room.
// Reset clears window lengths to 42 and 7, the fill count, pointers, queue and output valid.
module dual_window_average_balance #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    dwab_in_if.sink                             in_ch,
    dwab_out_if.source                          out_ch,
    input  logic                                cfg_wen,
    input  logic [dwab_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dwab_pkg::CFG_BITS-1:0]       cfg_data
);
    import dwab_pkg::*;

    // Extra depth keeps the window under read while the front writes ahead.
    localparam int HIST_DEPTH = MAX_WINDOW + QUEUE_DEPTH + 2;
    localparam int LEN_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int PTR_BITS   = $clog2(HIST_DEPTH);
    localparam int CMD_BITS   = PTR_BITS + 2 * LEN_BITS + 1;

    logic                   hist_we;
    logic [PTR_BITS-1:0]    hist_waddr, hist_raddr;
    logic [SAMPLE_BITS-1:0] hist_wdata, hist_rdata;
    logic                   cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CMD_BITS-1:0]    cmd_in, cmd_out;

    dwab_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .HIST_DEPTH  (HIST_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_in),
        .cmd_full   (cmd_full)
    );

    dwab_cmd_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    dwab_hist_ram #(
        .DEPTH (HIST_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    dwab_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .HIST_DEPTH  (HIST_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_data   (cmd_out),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .hist_raddr (hist_raddr),
        .hist_rdata (hist_rdata),
        .out_ch     (out_ch)
    );

endmodule

// File: test/tb.sv
// Testbench for dual_window_average_balance: drives samples, predicts balances, checks results.
`timescale 1ns / 1ps

module tb;
    import dwab_pkg::*;

    localparam int          SAMPLE_W      = 12;
    localparam int          WINDOW_MAX    = 64;
    localparam int          NUM_PHASES    = 14;
    localparam int          PHASE_ITEMS   = 138;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          STALL_LIMIT   = 5000;

    // Predicts the balance for each accepted sample and holds the balances still to arrive.
    class balance_predictor;
        bit [SAMPLE_W-1:0]        history [WINDOW_MAX];
        bit [6:0]                 fill_count;
        bit [5:0]                 write_slot;
        bit [CFG_BITS-1:0]        long_len;
        bit [CFG_BITS-1:0]        short_len;
        logic signed [SAMPLE_W:0] expected_balances [$];
        int                       errors;
        int                       samples_seen;
        int                       balances_seen;
        int                       series_ended;

        function new();
            long_len      = LONG_WINDOW_RESET;
            short_len     = SHORT_WINDOW_RESET;
            fill_count    = 0;
            write_slot    = 0;
            errors        = 0;
            samples_seen  = 0;
            balances_seen = 0;
            series_ended  = 0;
            foreach (history[i]) history[i] = '0;
        endfunction

        function void set_window(cfg_reg_t which, bit [CFG_BITS-1:0] value);
            if (which == REG_LONG_WINDOW)
                long_len = value;
            else
                short_len = value;
        endfunction

        function int unsigned clamp_window(bit [CFG_BITS-1:0] value);
            if (value == 0)
                return 1;
            if (value > WINDOW_MAX)
                return WINDOW_MAX;
            return 32'(value);
        endfunction

        function int pending();
            return expected_balances.size();
        endfunction

        function void predict_balance(bit [SAMPLE_W-1:0] sample, bit last);
            int unsigned l_eff;
            int unsigned s_eff;
            bit [5:0]    rd;
            longint      long_acc;
            longint      short_acc;
            longint      num;
            longint      den;
            longint      mag;
            longint      q;

            l_eff = clamp_window(long_len);
            s_eff = clamp_window(short_len);
            if (s_eff > l_eff)
                s_eff = l_eff;
            samples_seen++;

            history[write_slot] = sample;
            write_slot++;
            if (fill_count < WINDOW_MAX)
                fill_count++;

            if (fill_count >= l_eff) begin
                long_acc  = 0;
                short_acc = 0;
                for (int k = 1; k <= l_eff; k++) begin
                    rd = write_slot - 6'(k);
                    long_acc += longint'(history[rd]);
                    if (k <= s_eff)
                        short_acc += longint'(history[rd]);
                end
                // Exact difference of the two means, rounded half away from zero.
                num = long_acc * longint'(s_eff) - short_acc * longint'(l_eff);
                den = longint'(l_eff) * longint'(s_eff);
                mag = (num < 0) ? -num : num;
                q   = (2 * mag + den) / (2 * den);
                if (num < 0)
                    q = -q;
                expected_balances.push_back(q[SAMPLE_W:0]);
            end

            if (last) begin
                fill_count = 0;
                series_ended++;
            end
        endfunction

        function void check_balance(logic signed [SAMPLE_W:0] got);
            logic signed [SAMPLE_W:0] want;

            if (expected_balances.size() == 0) begin
                $error("balance %0d arrived with no expected value", got);
                errors++;
                return;
            end
            want = expected_balances.pop_front();
            balances_seen++;
            if (got !== want) begin
                $error("balance mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wen;
    cfg_reg_t          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    dwab_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    dwab_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

    dual_window_average_balance #(
        .MAX_WINDOW  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    balance_predictor predictor = new();
    int unsigned      idle_cycles = 0;
    bit               src_gaps    = 1'b1;
    bit               sink_stalls = 1'b1;
    bit               hold_request = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(0, 15));
            3:       return SAMPLE_W'($urandom_range(4080, 4095));
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic int unsigned series_length(int unsigned l_eff);
        if ($urandom_range(0, 9) < 8)
            return l_eff + $urandom_range(0, 60);
        return $urandom_range(1, l_eff + 1);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
        int unsigned gap;

        in_ch.valid          <= 1'b1;
        in_ch.sample         <= sample;
        in_ch.last_of_series <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        gap = src_gaps ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_windows(input logic [CFG_BITS-1:0] long_val,
                               input logic [CFG_BITS-1:0] short_val);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_LONG_WINDOW;
        cfg_data  <= long_val;
        @(posedge clk);
        cfg_index <= REG_SHORT_WINDOW;
        cfg_data  <= short_val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        predictor.set_window(REG_LONG_WINDOW, long_val);
        predictor.set_window(REG_SHORT_WINDOW, short_val);
    endtask

    // Samples that yield no balance may still sit in the command queue after the
    // last balance has arrived, so the settle time covers one full computation.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (predictor.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            predictor.check_balance(out_ch.balance);
        if (in_ch.valid && in_ch.ready)
            predictor.predict_balance(in_ch.sample, in_ch.last_of_series);
        if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that lets the block fill up.
    initial
    begin
        int unsigned stall_left;

        stall_left   = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int unsigned         series_left;
        int unsigned         l_eff;
        logic [CFG_BITS-1:0] long_set;
        logic [CFG_BITS-1:0] short_set;
        int unsigned         phase_long [11];
        int unsigned         phase_short [11];

        phase_long           = '{42, 1, 2, 64, 127, 64, 5, 0, 16, 127, 33};
        phase_short          = '{7, 1, 1, 1, 127, 64, 9, 0, 4, 0, 32};
        rst_n                <= 1'b0;
        cfg_wen              <= 1'b0;
        cfg_index            <= REG_LONG_WINDOW;
        cfg_data             <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.sample         <= '0;
        in_ch.last_of_series <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two-sample long window: odd differences land exactly on a half.
        set_windows(2, 1);
        send_sample(12'd0, 1'b0);
        send_sample(12'd1, 1'b0);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd4095, 1'b1);
        wait_for_results();

        // Zero long length acts as one; an oversized short length is cut back to it.
        set_windows(0, 127);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b1);
        wait_for_results();

        set_windows(3, 0);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b0);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd1, 1'b0);
        wait_for_results();

        // The series goes on across the change of window sizes.
        set_windows(3, 2);
        send_sample(12'd3, 1'b0);
        send_sample(12'd4, 1'b1);
        wait_for_results();

        series_left = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 11)
            begin
                long_set  = CFG_BITS'(phase_long[p]);
                short_set = CFG_BITS'(phase_short[p]);
            end
            else
            begin
                long_set  = CFG_BITS'($urandom_range(0, 127));
                short_set = CFG_BITS'($urandom_range(0, 127));
            end
            set_windows(long_set, short_set);
            l_eff = predictor.clamp_window(long_set);
            src_gaps    = (p != 2) && (p != 9);
            sink_stalls = (p != 1) && (p != 9);
            if (p == 3)
                hold_request = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (series_left == 0)
                    series_left = series_length(l_eff);
                series_left--;
                send_sample(pick_sample(), series_left == 0);
                if (p == 6 && i == PHASE_ITEMS / 2)
                    wait_for_results();
            end
            wait_for_results();
        end

        $display("Checked %0d balances from %0d samples in %0d finished series,",
                 predictor.balances_seen, predictor.samples_seen, predictor.series_ended);
        $display("over %0d window settings with stalls, a long output hold and a full drain.",
                 NUM_PHASES + 4);
        if (predictor.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dwab_pkg.sv
hw/rtl/dwab_if.sv
hw/rtl/dwab_cmd_fifo.sv
hw/rtl/dwab_hist_ram.sv
hw/rtl/dwab_front.sv
hw/rtl/dwab_back.sv
hw/rtl/dual_window_average_balance.sv
test/tb.sv
